FILE: design/cra_pkg.sv
// cra_pkg: types, constants and command codes for the contiguous region allocator
// no dependencies; imported by every module of the block
package cra_pkg;

  localparam int MaxRegions = 16;
  localparam int AddrBits   = 20;
  localparam int OwnerBits  = 8;
  localparam int IdxBits    = $clog2(MaxRegions);
  localparam int CntBits    = $clog2(MaxRegions + 1);
  localparam int SizeBits   = AddrBits + 1;
  localparam int QDepth     = 2;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_COMPACT = 2'd2,
    KIND_DUMP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_ALT   = 2'd3
  } strat_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_NO_OWNER  = 3'd3,
    ST_FULL      = 3'd4,
    ST_RSV5      = 3'd5,
    ST_RSV6      = 3'd6,
    ST_RSV7      = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  owner_id;
    logic [20:0] request_size;
    logic [1:0]  strategy;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] region_start;
    logic [19:0] region_end;
    logic [7:0]  region_owner;
    logic        region_is_hole;
    logic        last;
  } rsp_t;

  // classified command passed from the front end to the engine
  typedef struct packed {
    kind_t                 kind;
    logic [OwnerBits-1:0]  owner;
    logic [SizeBits-1:0]   size;
    strat_t                strat;
    logic                  size_zero;
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_REQ_DECIDE,
    S_SHIFT_UP,
    S_REQ_WRITE,
    S_REL_SCAN,
    S_REL_MERGE_HI,
    S_REL_MERGE_LO,
    S_SHIFT_DOWN,
    S_CMP_SCAN,
    S_CMP_TOP,
    S_DUMP,
    S_EMIT
  } eng_state_t;

endpackage

FILE: design/cra_front.sv
// cra_front: input beat acceptance, classification and a short command queue
// depends on cra_pkg
module cra_front
  import cra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output op_t  q_op
);

  localparam int PtrBits = $clog2(QDepth);

  op_t                q_mem [QDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   fill;
  op_t                op_in;
  logic               push;
  logic               pop;

  always_comb begin
    op_in.kind      = kind_t'(in_data.kind);
    op_in.owner     = in_data.owner_id[OwnerBits-1:0];
    op_in.size      = in_data.request_size[SizeBits-1:0];
    op_in.strat     = strat_t'(in_data.strategy);
    op_in.size_zero = (in_data.request_size == '0);
  end

  assign in_ready = (fill != (PtrBits+1)'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_ready;
  assign q_op     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrBits+1)'(QDepth)) else $error("queue overfill");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> !q_valid) else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1)) else $error("fill count slip");

endmodule

FILE: design/cra_engine.sv
// cra_engine: region table and the sequencer that carries out commands
// depends on cra_pkg; fed by cra_front, drives an output register
module cra_engine
  import cra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SizeBits-1:0] cfg_data,
  input  logic                q_valid,
  output logic                q_ready,
  input  op_t                 q_op,
  output logic                out_valid,
  input  logic                out_ready,
  output rsp_t                out_data
);

  logic [AddrBits-1:0]  tab_start [MaxRegions];
  logic [AddrBits-1:0]  tab_end   [MaxRegions];
  logic [OwnerBits-1:0] tab_owner [MaxRegions];
  logic                 tab_hole  [MaxRegions];

  logic [CntBits-1:0]   count;
  logic [SizeBits-1:0]  free_units;
  logic [SizeBits-1:0]  total_size;

  eng_state_t           state, state_next;
  op_t                  op;
  logic [CntBits-1:0]   idx;
  logic [IdxBits-1:0]   pick;
  logic                 found;
  logic [SizeBits-1:0]  best;
  logic [CntBits-1:0]   ncomp;
  logic [SizeBits-1:0]  pos;
  logic [CntBits-1:0]   rm_idx;
  logic                 merge_lo;
  logic                 out_full;
  logic                 cfg_fire;
  logic [SizeBits-1:0]  cfg_clamped;

  logic [IdxBits-1:0]   ix;
  logic [SizeBits-1:0]  cur_len;
  logic                 cur_fits;
  logic                 take;

  assign ix       = idx[IdxBits-1:0];
  assign cur_len  = {1'b0, tab_end[ix]} - {1'b0, tab_start[ix]} + 1'b1;
  assign cur_fits = tab_hole[ix] && (cur_len >= op.size);
  assign take     = cur_fits && (!found || (op.strat == STRAT_BEST && cur_len < best)
                    || (op.strat == STRAT_WORST && cur_len > best));

  assign cfg_ready = (state == S_IDLE) && !out_full && !q_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign q_ready   = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) cfg_clamped = SizeBits'(1);
    if (cfg_data > (SizeBits'(1) << AddrBits)) cfg_clamped = SizeBits'(1) << AddrBits;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid && q_ready) begin
          unique case (q_op.kind)
            KIND_REQUEST: state_next = S_SCAN;
            KIND_RELEASE: state_next = S_REL_SCAN;
            KIND_COMPACT: state_next = S_CMP_SCAN;
            KIND_DUMP:    state_next = S_DUMP;
          endcase
        end
      end
      S_SCAN: begin
        if (op.size_zero || op.size > free_units) state_next = S_EMIT;
        else if (idx == count) state_next = S_REQ_DECIDE;
        else if (take && op.strat != STRAT_BEST && op.strat != STRAT_WORST)
          state_next = S_REQ_DECIDE;
      end
      S_REQ_DECIDE: begin
        if (!found) state_next = S_EMIT;
        else if (best == op.size) state_next = S_REQ_WRITE;
        else if (count >= CntBits'(MaxRegions)) state_next = S_EMIT;
        else state_next = S_SHIFT_UP;
      end
      S_SHIFT_UP:  if (idx == CntBits'(pick)) state_next = S_REQ_WRITE;
      S_REQ_WRITE: state_next = S_EMIT;
      S_REL_SCAN: begin
        if (idx == count) state_next = S_EMIT;
        else if (!tab_hole[ix] && tab_owner[ix] == op.owner) state_next = S_REL_MERGE_HI;
      end
      S_REL_MERGE_HI: state_next = S_SHIFT_DOWN;
      S_REL_MERGE_LO: state_next = S_SHIFT_DOWN;
      S_SHIFT_DOWN: begin
        if (rm_idx == '0 || idx + 1'b1 >= count) begin
          state_next = merge_lo ? S_REL_MERGE_LO : S_EMIT;
        end
      end
      S_CMP_SCAN: if (idx == count) state_next = S_CMP_TOP;
      S_CMP_TOP:  state_next = S_EMIT;
      S_DUMP:     if ((!out_full || out_ready) && idx + 1'b1 == count) state_next = S_IDLE;
      S_EMIT:     if (!out_full) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_full   <= 1'b0;
      total_size <= SizeBits'(1) << AddrBits;
      free_units <= SizeBits'(1) << AddrBits;
      count      <= CntBits'(1);
      tab_start[0] <= '0;
      tab_end[0]   <= '1;
      tab_hole[0]  <= 1'b1;
    end else begin
      state <= state_next;
      if (out_full && out_ready && state != S_DUMP) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            total_size   <= cfg_clamped;
            free_units   <= cfg_clamped;
            count        <= CntBits'(1);
            tab_start[0] <= '0;
            tab_end[0]   <= AddrBits'(cfg_clamped - 1'b1);
            tab_hole[0]  <= 1'b1;
          end else if (q_valid && q_ready) begin
            op    <= q_op;
            idx   <= '0;
            found <= 1'b0;
            best  <= '0;
            ncomp <= '0;
            pos   <= '0;
            out_data <= '0;
            out_data.last <= 1'b1;
            out_data.status <= ST_OK;
          end
        end
        S_SCAN: begin
          if (op.size_zero) out_data.status <= ST_NO_FIT;
          else if (op.size > free_units) out_data.status <= ST_NO_FREE;
          else if (idx != count) begin
            if (take) begin
              found <= 1'b1;
              pick  <= ix;
              best  <= cur_len;
            end
            idx <= idx + 1'b1;
          end
        end
        S_REQ_DECIDE: begin
          idx <= count;
          if (!found) out_data.status <= ST_NO_FIT;
          else if (best != op.size && count >= CntBits'(MaxRegions))
            out_data.status <= ST_FULL;
        end
        S_SHIFT_UP: begin
          if (idx != CntBits'(pick)) begin
            tab_start[ix] <= tab_start[ix - 1'b1];
            tab_end[ix]   <= tab_end[ix - 1'b1];
            tab_owner[ix] <= tab_owner[ix - 1'b1];
            tab_hole[ix]  <= tab_hole[ix - 1'b1];
            idx <= idx - 1'b1;
          end else begin
            count <= count + 1'b1;
            tab_start[pick + 1'b1] <= AddrBits'({1'b0, tab_start[pick]} + op.size);
          end
        end
        S_REQ_WRITE: begin
          tab_end[pick]   <= AddrBits'({1'b0, tab_start[pick]} + op.size - 1'b1);
          tab_owner[pick] <= op.owner;
          tab_hole[pick]  <= 1'b0;
          free_units <= free_units - op.size;
          out_data.region_start <= tab_start[pick];
          out_data.region_end   <= AddrBits'({1'b0, tab_start[pick]} + op.size - 1'b1);
          out_data.region_owner <= 8'(op.owner);
        end
        S_REL_SCAN: begin
          if (idx == count) out_data.status <= ST_NO_OWNER;
          else if (!tab_hole[ix] && tab_owner[ix] == op.owner) begin
            pick <= ix;
            tab_hole[ix]  <= 1'b1;
            tab_owner[ix] <= '0;
            free_units <= free_units + cur_len;
            out_data.region_start   <= tab_start[ix];
            out_data.region_end     <= tab_end[ix];
            out_data.region_is_hole <= 1'b1;
          end else idx <= idx + 1'b1;
        end
        S_REL_MERGE_HI: begin
          merge_lo <= (pick != '0) && tab_hole[pick - 1'b1];
          if (CntBits'(pick) + 1'b1 < count && tab_hole[pick + 1'b1]) begin
            tab_end[pick] <= tab_end[pick + 1'b1];
            rm_idx <= CntBits'(pick) + 1'b1;
            idx    <= CntBits'(pick) + 1'b1;
          end else begin
            rm_idx <= '0;
          end
        end
        S_REL_MERGE_LO: begin
          merge_lo <= 1'b0;
          tab_end[pick - 1'b1] <= tab_end[pick];
          rm_idx <= CntBits'(pick);
          idx    <= CntBits'(pick);
        end
        S_SHIFT_DOWN: begin
          if (rm_idx != '0) begin
            if (idx + 1'b1 < count) begin
              tab_start[ix] <= tab_start[ix + 1'b1];
              tab_end[ix]   <= tab_end[ix + 1'b1];
              tab_owner[ix] <= tab_owner[ix + 1'b1];
              tab_hole[ix]  <= tab_hole[ix + 1'b1];
              idx <= idx + 1'b1;
            end else begin
              count <= count - 1'b1;
              rm_idx <= '0;
            end
          end
        end
        S_CMP_SCAN: begin
          if (idx != count) begin
            if (!tab_hole[ix]) begin
              tab_start[ncomp[IdxBits-1:0]] <= AddrBits'(pos);
              tab_end[ncomp[IdxBits-1:0]]   <= AddrBits'(pos + cur_len - 1'b1);
              tab_owner[ncomp[IdxBits-1:0]] <= tab_owner[ix];
              tab_hole[ncomp[IdxBits-1:0]]  <= 1'b0;
              pos   <= pos + cur_len;
              ncomp <= ncomp + 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        S_CMP_TOP: begin
          if (pos < total_size && ncomp < CntBits'(MaxRegions)) begin
            tab_start[ncomp[IdxBits-1:0]] <= AddrBits'(pos);
            tab_end[ncomp[IdxBits-1:0]]   <= AddrBits'(total_size - 1'b1);
            tab_owner[ncomp[IdxBits-1:0]] <= '0;
            tab_hole[ncomp[IdxBits-1:0]]  <= 1'b1;
            count <= ncomp + 1'b1;
            out_data.region_start   <= AddrBits'(pos);
            out_data.region_end     <= AddrBits'(total_size - 1'b1);
            out_data.region_is_hole <= 1'b1;
          end else count <= ncomp;
        end
        S_DUMP: begin
          if (!out_full || out_ready) begin
            out_full <= 1'b1;
            out_data.status         <= ST_OK;
            out_data.region_start   <= tab_start[ix];
            out_data.region_end     <= tab_end[ix];
            out_data.region_owner   <= tab_hole[ix] ? 8'd0 : 8'(tab_owner[ix]);
            out_data.region_is_hole <= tab_hole[ix];
            out_data.last           <= (idx + 1'b1 == count);
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_full) out_full <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CntBits'(1)) && (count <= CntBits'(MaxRegions)))
    else $error("region count out of range");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_units <= total_size) else $error("free units exceed total");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output beat changed while stalled");
  a_idle_take: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (state == S_IDLE)) else $error("command taken while busy");

endmodule

FILE: design/contiguous_region_allocator_unit.sv
// contiguous_region_allocator_unit: top level of the region allocator
// depends on cra_pkg, cra_front and cra_engine
//
// commands come in on in_valid/in_ready with a cmd_t beat; results leave on
// out_valid/out_ready as rsp_t beats. total_size is written on cfg_valid/
// cfg_ready while the block is idle and resets the table to one hole.
// a two-entry command queue lets new beats in while the engine works.
// each command walks the region table entry by entry:
//   request: scan for a fitting hole, then shift entries up unless it fits exactly
//   release: scan for the owner, then shift entries down, twice on a double merge
//   compact: one pass over the regions; status dump: one beat per region per cycle
// while the receiver keeps up. results leave through the output register; a stalled
// receiver holds the output register and the engine waits, the queue still fills.
// reset (rst, synchronous) leaves one hole of 2^20 units and an empty queue
module contiguous_region_allocator_unit
  import cra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data
);

  logic q_valid;
  logic q_ready;
  op_t  q_op;

  cra_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_op
  );

  cra_engine u_engine (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .q_valid, .q_ready, .q_op,
    .out_valid, .out_ready, .out_data
  );

endmodule
